[rtl/efp_pkg.sv]
`timescale 1ns / 1ps
package efp_pkg;

	localparam int FRAC_BITS     = 28;
	localparam int COORD_W       = 10;
	localparam int QUEUE_DEPTH   = 2;
	localparam int DEF_IMAGE_W   = 1024;
	localparam int DEF_IMAGE_H   = 1024;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 3;
	localparam int WIDE_W        = 48;

	localparam logic [30:0] ZOOM_RESET  = 31'h2000_0000;
	localparam logic [15:0] LIMIT_RESET = 16'd100;
	localparam logic [30:0] ESC_RESET   = 31'h4000_0000;
	localparam logic [47:0] COLOR_RESET = 48'hFFFF_FF00_0000;
	localparam logic [23:0] BLACK       = 24'h00_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KIND   = 3'd0,
		REG_ZOOM   = 3'd1,
		REG_OFF_X  = 3'd2,
		REG_OFF_Y  = 3'd3,
		REG_JULIA  = 3'd4,
		REG_LIMIT  = 3'd5,
		REG_ESCAPE = 3'd6,
		REG_COLOR  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic               fractal_kind;
		logic [30:0]        zoom_half_span;
		logic signed [31:0] view_offset_x;
		logic signed [31:0] view_offset_y;
		logic [63:0]        julia_constant;
		logic [15:0]        iteration_limit;
		logic [30:0]        escape_limit;
		logic [47:0]        color_endpoints;
	} cfg_t;

	typedef struct packed {
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
	} in_t;

	typedef struct packed {
		logic [9:0]  out_x;
		logic [9:0]  out_y;
		logic [23:0] pixel_color;
		logic        escaped;
		logic [15:0] escape_index;
	} out_t;

	// one mapped pixel between front and back
	typedef struct packed {
		logic [9:0]         px;
		logic [9:0]         py;
		logic signed [31:0] map_re;
		logic signed [31:0] map_im;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_START,
		F_WAIT,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ITER,
		B_CMUL,
		B_CSTART,
		B_CWAIT,
		B_FIN
	} back_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(32'sh7FFF_FFFF);
		lo = ~hi;
		if (v > hi)
			return 32'sh7FFF_FFFF;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

[rtl/escape_time_fractal_pixel.sv]
`timescale 1ns / 1ps
// escape-time fractal pixel (mandelbrot / julia) in signed q4.28. one pixel coordinate in,
// one colored pixel out. the front maps the coordinate onto the complex plane, dividing by
// the image size with a reciprocal multiply done in three 16-bit slices, and takes the next
// coordinate only once the last point is pushed. it hands the point through a two-entry
// queue to the back, which runs one z = z*z + c step per cycle on three 32x32 multipliers.
// a pixel that escapes is then colored by interpolation, which divides by the limit one
// bit per cycle. the front maps the next pixel while the back iterates, so the sustained
// rate is set by the back's iteration loop. configuration is written through cfg_we /
// cfg_index / cfg_data and must only change while no pixel is in flight.
module escape_time_fractal_pixel #(
	parameter int IMAGE_WIDTH  = efp_pkg::DEF_IMAGE_W,
	parameter int IMAGE_HEIGHT = efp_pkg::DEF_IMAGE_H
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [efp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [efp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  efp_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output efp_pkg::out_t               out_data
);
	import efp_pkg::*;

	cfg_t cfg_q;
	logic job_valid, job_ready;
	job_t job;
	logic q_valid, q_ready;
	job_t q_data;

	// configuration registers, one write per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fractal_kind    <= 1'b0;
			cfg_q.zoom_half_span  <= ZOOM_RESET;
			cfg_q.view_offset_x   <= '0;
			cfg_q.view_offset_y   <= '0;
			cfg_q.julia_constant  <= '0;
			cfg_q.iteration_limit <= LIMIT_RESET;
			cfg_q.escape_limit    <= ESC_RESET;
			cfg_q.color_endpoints <= COLOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KIND:   cfg_q.fractal_kind    <= cfg_data[0];
				REG_ZOOM:   cfg_q.zoom_half_span  <= cfg_data[30:0];
				REG_OFF_X:  cfg_q.view_offset_x   <= cfg_data[31:0];
				REG_OFF_Y:  cfg_q.view_offset_y   <= cfg_data[31:0];
				REG_JULIA:  cfg_q.julia_constant  <= cfg_data;
				REG_LIMIT:  cfg_q.iteration_limit <= cfg_data[15:0];
				REG_ESCAPE: cfg_q.escape_limit    <= cfg_data[30:0];
				REG_COLOR:  cfg_q.color_endpoints <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	// front: coordinate mapping
	efp_front #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job)
	);

	// decouples mapping from iteration
	efp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(job_valid),
		.push_ready(job_ready),
		.push_data (job),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_data)
	);

	// back: iteration, coloring and output register
	efp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job_valid(q_valid),
		.job_ready(q_ready),
		.job      (q_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);
endmodule

[rtl/efp_div.sv]
`timescale 1ns / 1ps
module efp_div #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

[rtl/efp_front.sv]
`timescale 1ns / 1ps
module efp_front #(
	parameter int IMAGE_WIDTH  = efp_pkg::DEF_IMAGE_W,
	parameter int IMAGE_HEIGHT = efp_pkg::DEF_IMAGE_H
) (
	input  logic          clk,
	input  logic          arst_n,
	input  efp_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  efp_pkg::in_t  in_data,
	output logic          job_valid,
	input  logic          job_ready,
	output efp_pkg::job_t job
);
	import efp_pkg::*;

	localparam int PROD_W  = 32 + COORD_W;
	localparam int CHUNK_W = 16;
	localparam int N_CHUNK = 3;
	localparam int RCP_W   = CHUNK_W * N_CHUNK;
	localparam int PART_W  = PROD_W + CHUNK_W;
	localparam int ACC_W   = PART_W + 1;
	localparam int LOG_W   = $clog2(IMAGE_WIDTH);
	localparam int LOG_H   = $clog2(IMAGE_HEIGHT);
	localparam int SHIFT_X = PROD_W + LOG_W - (N_CHUNK - 1) * CHUNK_W;
	localparam int SHIFT_Y = PROD_W + LOG_H - (N_CHUNK - 1) * CHUNK_W;

	// floor(2**(n+l)/d) + 1 gives an exact floor quotient for any n-bit numerator
	localparam logic [RCP_W-1:0] RCP_X =
		RCP_W'((64'd1 << (PROD_W + LOG_W)) / 64'(IMAGE_WIDTH) + 64'd1);
	localparam logic [RCP_W-1:0] RCP_Y =
		RCP_W'((64'd1 << (PROD_W + LOG_H)) / 64'(IMAGE_HEIGHT) + 64'd1);

	front_state_t state_q, state_d;

	logic [9:0]        px_q, py_q;
	logic [PROD_W-1:0] prod_x_q, prod_y_q;
	logic [31:0]       span;
	logic              start;
	logic              busy_q, done_q;
	logic [1:0]        step_q;
	logic [CHUNK_W-1:0] chunk_x, chunk_y;
	logic [PART_W-1:0] part_x, part_y;
	logic [ACC_W-1:0]  acc_x_q, acc_y_q;
	logic [PROD_W-1:0] quot_x, quot_y;
	logic signed [WIDE_W-1:0] re_wide, im_wide;

	assign span = {cfg.zoom_half_span, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		start     = 1'b0;
		job_valid = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = F_START;
			end
			F_START: begin
				start   = 1'b1;
				state_d = F_WAIT;
			end
			F_WAIT: begin
				if (done_q)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				job_valid = 1'b1;
				if (job_ready)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_q     <= in_data.pixel_x;
			py_q     <= in_data.pixel_y;
			prod_x_q <= span * in_data.pixel_x;
			prod_y_q <= span * in_data.pixel_y;
		end
	end

	// division by the image size as a reciprocal multiply, one 16-bit slice per cycle
	assign chunk_x = RCP_X[step_q * CHUNK_W +: CHUNK_W];
	assign chunk_y = RCP_Y[step_q * CHUNK_W +: CHUNK_W];
	assign part_x  = prod_x_q * chunk_x;
	assign part_y  = prod_y_q * chunk_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= 2'd1;
		end else if (busy_q) begin
			if (step_q == 2'(N_CHUNK - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// low slice first; dropping 16 bits per step keeps the running floor exact
	always_ff @(posedge clk) begin
		if (start) begin
			acc_x_q <= ACC_W'(part_x);
			acc_y_q <= ACC_W'(part_y);
		end else if (busy_q) begin
			acc_x_q <= (acc_x_q >> CHUNK_W) + ACC_W'(part_x);
			acc_y_q <= (acc_y_q >> CHUNK_W) + ACC_W'(part_y);
		end
	end

	assign quot_x = PROD_W'(acc_x_q >> SHIFT_X);
	assign quot_y = PROD_W'(acc_y_q >> SHIFT_Y);

	assign re_wide = WIDE_W'(cfg.view_offset_x) - $signed(WIDE_W'(cfg.zoom_half_span))
		+ $signed(WIDE_W'(quot_x));
	assign im_wide = WIDE_W'(cfg.view_offset_y) + $signed(WIDE_W'(cfg.zoom_half_span))
		- $signed(WIDE_W'(quot_y));

	assign job.px     = px_q;
	assign job.py     = py_q;
	assign job.map_re = sat32(re_wide);
	assign job.map_im = sat32(im_wide);
endmodule

[rtl/efp_queue.sv]
`timescale 1ns / 1ps
module efp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  efp_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output efp_pkg::job_t pop_data
);
	import efp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end
endmodule

[rtl/efp_back.sv]
`timescale 1ns / 1ps
module efp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  efp_pkg::cfg_t cfg,
	input  logic          job_valid,
	output logic          job_ready,
	input  efp_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_ready,
	output efp_pkg::out_t out_data
);
	import efp_pkg::*;

	localparam int CPROD_W = 41;

	back_state_t state_q, state_d;

	logic signed [31:0] zr_q, zi_q, cr_q, ci_q;
	logic [15:0]        t_q, limit_q, idx_q;
	logic [9:0]         px_q, py_q;
	logic               esc_q, neg_q;
	logic [23:0]        color_q;
	logic [CPROD_W-1:0] cmag_q;

	logic signed [63:0]       p_rr, p_ii, p_ri;
	logic signed [WIDE_W-1:0] rr, ii, ri, mag;
	logic                     hit;
	logic [23:0]              cs, ce;
	logic signed [24:0]       cdiff;
	logic signed [41:0]       cprod;
	logic                     cstart, cdone;
	logic [CPROD_W-1:0]       cquot;
	logic [23:0]              q24;
	logic                     load_out;
	logic                     out_valid_q;
	out_t                     out_q;

	// one complex step per cycle; the escape test of z uses the squares of z
	assign p_rr = zr_q * zr_q;
	assign p_ii = zi_q * zi_q;
	assign p_ri = zr_q * zi_q;
	assign rr   = WIDE_W'(p_rr >>> FRAC_BITS);
	assign ii   = WIDE_W'(p_ii >>> FRAC_BITS);
	assign ri   = WIDE_W'(p_ri >>> (FRAC_BITS - 1));
	assign mag  = rr + ii;
	assign hit  = (t_q != '0) && (mag > $signed(WIDE_W'(cfg.escape_limit)));

	assign cs    = cfg.color_endpoints[47:24];
	assign ce    = cfg.color_endpoints[23:0];
	assign cdiff = $signed({1'b0, ce}) - $signed({1'b0, cs});
	assign cprod = cdiff * $signed({1'b0, idx_q});
	assign q24   = cquot[23:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		cstart    = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				job_ready = 1'b1;
				if (job_valid)
					state_d = (cfg.iteration_limit == '0) ? B_FIN : B_ITER;
			end
			B_ITER: begin
				if (hit)
					state_d = B_CMUL;
				else if (t_q == limit_q)
					state_d = B_FIN;
			end
			B_CMUL:   state_d = B_CSTART;
			B_CSTART: begin
				cstart  = 1'b1;
				state_d = B_CWAIT;
			end
			B_CWAIT: begin
				if (cdone)
					state_d = B_FIN;
			end
			B_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				px_q    <= job.px;
				py_q    <= job.py;
				limit_q <= cfg.iteration_limit;
				t_q     <= '0;
				esc_q   <= 1'b0;
				idx_q   <= '0;
				color_q <= BLACK;
				if (cfg.fractal_kind) begin
					zr_q <= job.map_re;
					zi_q <= job.map_im;
					cr_q <= cfg.julia_constant[63:32];
					ci_q <= cfg.julia_constant[31:0];
				end else begin
					zr_q <= '0;
					zi_q <= '0;
					cr_q <= job.map_re;
					ci_q <= job.map_im;
				end
			end
			B_ITER: begin
				if (hit) begin
					esc_q <= 1'b1;
					idx_q <= t_q - 1'b1;
				end else if (t_q == limit_q) begin
					idx_q <= limit_q;
				end else begin
					zr_q <= sat32(rr - ii + WIDE_W'(cr_q));
					zi_q <= sat32(ri + WIDE_W'(ci_q));
					t_q  <= t_q + 1'b1;
				end
			end
			B_CMUL: begin
				neg_q  <= cprod[41];
				cmag_q <= cprod[41] ? CPROD_W'(-cprod) : cprod[CPROD_W-1:0];
			end
			B_CWAIT: begin
				if (cdone)
					color_q <= cs + (neg_q ? (~q24 + 24'd1) : q24);
			end
			default: ;
		endcase
	end

	efp_div #(.NUM_W(CPROD_W), .DEN_W(16)) u_cdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cstart),
		.num   (cmag_q),
		.den   (limit_q),
		.done  (cdone),
		.quot  (cquot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.out_x        <= px_q;
			out_q.out_y        <= py_q;
			out_q.pixel_color  <= color_q;
			out_q.escaped      <= esc_q;
			out_q.escape_index <= idx_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

[verif/tb_escape_time_fractal_pixel.sv]
`timescale 1ns / 1ps
module tb_escape_time_fractal_pixel;
	import efp_pkg::*;

	localparam int  IMG_W      = 1024;
	localparam int  IMG_H      = 1024;
	localparam int  STUCK_MAX  = 250000;  // longer than one non-escaping pixel at limit 65535
	localparam int  HOLD_LEN   = 4000;    // long receiver hold-off, fills the block

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	logic  [CFG_INDEX_W-1:0] cfg_index;
	logic  [CFG_DATA_W-1:0]  cfg_data;
	logic  in_valid;
	logic  in_ready;
	in_t   in_data;
	logic  out_valid;
	logic  out_ready;
	out_t  out_data;

	escape_time_fractal_pixel #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// shadow copy of the configuration, kept in step with every register write
	logic               sh_kind;
	logic [30:0]        sh_zoom;
	logic signed [31:0] sh_off_x;
	logic signed [31:0] sh_off_y;
	logic [63:0]        sh_julia;
	logic [15:0]        sh_limit;
	logic [30:0]        sh_escape;
	logic [47:0]        sh_color;

	in_t  pixel_pending_q[$];  // pixels waiting to be offered
	out_t pixel_expect_q[$];   // predicted colored pixels, oldest first
	int   mismatch_cnt;
	int   colored_cnt;
	int   stuck_cycles;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		else if (v < -64'sd2147483648)
			return -64'sd2147483648;
		else
			return v;
	endfunction

	// escape-time iteration in q4.28, products floored by arithmetic shift
	function automatic out_t color_pixel(input in_t px);
		out_t   r;
		longint zoom, span, map_re, map_im;
		longint zr, zi, cr, ci, rr, ii, ri, mag;
		longint lim, i, cs, ce, v;
		zoom   = longint'(sh_zoom);
		span   = 2 * zoom;
		map_re = clamp32(longint'(sh_off_x) - zoom + (span * longint'(px.pixel_x)) / IMG_W);
		map_im = clamp32(longint'(sh_off_y) + zoom - (span * longint'(px.pixel_y)) / IMG_H);
		lim    = longint'(sh_limit);
		if (sh_kind == 1'b0) begin
			zr = 0;
			zi = 0;
			cr = map_re;
			ci = map_im;
		end else begin
			zr = map_re;
			zi = map_im;
			cr = longint'($signed(sh_julia[63:32]));
			ci = longint'($signed(sh_julia[31:0]));
		end
		r.out_x        = px.pixel_x;
		r.out_y        = px.pixel_y;
		r.pixel_color  = BLACK;
		r.escaped      = 1'b0;
		r.escape_index = sh_limit;
		for (i = 0; i < lim; i++) begin
			rr  = (zr * zr) >>> FRAC_BITS;
			ii  = (zi * zi) >>> FRAC_BITS;
			ri  = (zr * zi) >>> (FRAC_BITS - 1);
			zr  = clamp32(rr - ii + cr);
			zi  = clamp32(ri + ci);
			mag = ((zr * zr) >>> FRAC_BITS) + ((zi * zi) >>> FRAC_BITS);
			if (mag > longint'(32'hFFFF_FFFF))
				mag = longint'(32'hFFFF_FFFF);
			if (mag > longint'(sh_escape)) begin
				cs = longint'(sh_color[47:24]);
				ce = longint'(sh_color[23:0]);
				v  = cs + ((ce - cs) * i) / lim;
				r.pixel_color  = v[23:0];
				r.escaped      = 1'b1;
				r.escape_index = i[15:0];
				break;
			end
		end
		return r;
	endfunction

	// sender: bursts of random length, random gaps between them
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_data    <= '0;
			burst_left <= 1;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready)
				pixel_expect_q.push_back(color_pixel(in_data));
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || pixel_pending_q.size() == 0) begin
					if (gap_left > 0)
						gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_data  <= pixel_pending_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						// no gap at all about half the time
						gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 150);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// receiver: stall pattern that changes mode now and then, plus one long hold-off
	int  stall_mode;
	int  mode_left;
	int  hold_left;
	bit  hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_mode <= 0;
			mode_left  <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
		end else begin
			if (!hold_done && colored_cnt >= 30) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_LEN;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode <= $urandom_range(0, 3);
					mode_left  <= $urandom_range(50, 2000);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 1) == 0);
					default: out_ready <= ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	// result checker, one transfer per accepting edge
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			colored_cnt <= colored_cnt + 1;
			if (pixel_expect_q.size() == 0) begin
				$display("%0t: unexpected pixel transfer, actual %p", $time, out_data);
				mismatch_cnt++;
			end else begin
				want = pixel_expect_q.pop_front();
				if (out_data.out_x !== want.out_x) begin
					$display("%0t: out_x expected %0d actual %0d", $time, want.out_x,
						out_data.out_x);
					mismatch_cnt++;
				end
				if (out_data.out_y !== want.out_y) begin
					$display("%0t: out_y expected %0d actual %0d", $time, want.out_y,
						out_data.out_y);
					mismatch_cnt++;
				end
				if (out_data.pixel_color !== want.pixel_color) begin
					$display("%0t: pixel_color expected %h actual %h", $time,
						want.pixel_color, out_data.pixel_color);
					mismatch_cnt++;
				end
				if (out_data.escaped !== want.escaped) begin
					$display("%0t: escaped expected %b actual %b", $time, want.escaped,
						out_data.escaped);
					mismatch_cnt++;
				end
				if (out_data.escape_index !== want.escape_index) begin
					$display("%0t: escape_index expected %0d actual %0d", $time,
						want.escape_index, out_data.escape_index);
					mismatch_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_MAX) begin
			$display("escape_time_fractal_pixel regression: fail");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_KIND:   sh_kind   = val[0];
			REG_ZOOM:   sh_zoom   = val[30:0];
			REG_OFF_X:  sh_off_x  = val[31:0];
			REG_OFF_Y:  sh_off_y  = val[31:0];
			REG_JULIA:  sh_julia  = val;
			REG_LIMIT:  sh_limit  = val[15:0];
			REG_ESCAPE: sh_escape = val[30:0];
			default:    sh_color  = val[47:0];
		endcase
	endtask

	// every pixel yields one result, so an empty expectation store means idle
	task automatic wait_idle();
		while (pixel_pending_q.size() != 0 || in_valid || pixel_expect_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic set_view(input logic kind, input logic [30:0] zoom,
			input logic [31:0] ox, input logic [31:0] oy, input logic [63:0] jc,
			input logic [15:0] lim, input logic [30:0] esc, input logic [47:0] col);
		wait_idle();
		write_reg(REG_KIND, {63'd0, kind});
		write_reg(REG_ZOOM, {33'd0, zoom});
		write_reg(REG_OFF_X, {32'd0, ox});
		write_reg(REG_OFF_Y, {32'd0, oy});
		write_reg(REG_JULIA, jc);
		write_reg(REG_LIMIT, {48'd0, lim});
		write_reg(REG_ESCAPE, {33'd0, esc});
		write_reg(REG_COLOR, {16'd0, col});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_pixel(input int x, input int y);
		in_t p;
		p.pixel_x = x[9:0];
		p.pixel_y = y[9:0];
		pixel_pending_q.push_back(p);
	endtask

	// small q4.28 value within +-2.0
	function automatic logic [31:0] near_origin();
		return 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
	endfunction

	initial begin
		logic [30:0] zoom;
		logic [31:0] ox, oy;
		logic [15:0] lim;
		logic [30:0] esc;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		mismatch_cnt = 0;
		colored_cnt  = 0;
		stuck_cycles = 0;
		sh_kind      = 1'b0;
		sh_zoom      = ZOOM_RESET;
		sh_off_x     = '0;
		sh_off_y     = '0;
		sh_julia     = '0;
		sh_limit     = LIMIT_RESET;
		sh_escape    = ESC_RESET;
		sh_color     = COLOR_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset view: corners, center, alternating bit patterns
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(0, 1023);
		queue_pixel(1023, 0);
		queue_pixel(512, 512);
		queue_pixel(341, 682);
		queue_pixel(682, 341);

		// zero iteration limit never iterates
		set_view(1'b0, ZOOM_RESET, '0, '0, '0, 16'd0, ESC_RESET, COLOR_RESET);
		queue_pixel(100, 900);
		queue_pixel(512, 512);

		// julia with the widest zoom and extreme offsets, saturating mapping
		set_view(1'b1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			64'h8000_0000_7FFF_FFFF, 16'd20, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(512, 512);
		set_view(1'b1, 31'd0, 32'h8000_0000, 32'h7FFF_FFFF,
			64'hF400_0000_0A00_0000, 16'd1, 31'd0, 48'h0000_00FF_FFFF);
		queue_pixel(7, 9);
		queue_pixel(1023, 0);

		// classic julia and a zero escape limit
		set_view(1'b1, ZOOM_RESET, '0, '0, 64'hF400_0000_0A00_0000, 16'd50,
			ESC_RESET, 48'h1234_5600_0000);
		queue_pixel(300, 700);
		queue_pixel(600, 200);
		set_view(1'b0, ZOOM_RESET, '0, '0, '0, 16'd30, 31'd0, 48'h00FF_00FF_00FF);
		queue_pixel(512, 512);

		// largest limit: center never escapes, corners escape at once
		set_view(1'b0, ZOOM_RESET, '0, '0, '0, 16'hFFFF, ESC_RESET, COLOR_RESET);
		queue_pixel(512, 512);
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(384, 512);

		// random views, mostly near the interesting region with modest limits
		repeat (13) begin
			zoom = ($urandom_range(0, 7) == 0) ? 31'($urandom) :
				31'($urandom_range(32'h0010_0000, 32'h3000_0000));
			ox   = ($urandom_range(0, 7) == 0) ? $urandom : near_origin();
			oy   = ($urandom_range(0, 7) == 0) ? $urandom : near_origin();
			lim  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 400)) :
				16'($urandom_range(1, 150));
			esc  = ($urandom_range(0, 7) == 0) ? 31'($urandom) :
				31'($urandom_range(32'h1000_0000, 32'h4000_0000));
			set_view(1'($urandom), zoom, ox, oy,
				($urandom_range(0, 5) == 0) ? {$urandom, $urandom} :
				{$signed(near_origin()) >>> 1, $signed(near_origin()) >>> 1}, lim, esc,
				{16'($urandom), $urandom});
			repeat (128) queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (mismatch_cnt == 0 && pixel_expect_q.size() == 0)
			$display("escape_time_fractal_pixel regression: pass");
		else
			$display("escape_time_fractal_pixel regression: fail");
		$finish;
	end

endmodule
